>>> hw/rtl/lkt_pkg.sv
// Shared types and constants for the LRU key tracker.
package lkt_pkg;

    localparam int KEY_W      = 32;
    localparam int CNT_W      = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic advance;   // a word is accepted this cycle
        logic room;      // a miss inserts without eviction
        cnt_t used;      // occupied entries before this access
    } lkt_ctl_t;

endpackage

>>> hw/rtl/lkt_if.sv
// Valid/ready channel interfaces for the request and response words.
interface lkt_req_if;
    import lkt_pkg::*;

    logic valid;
    logic ready;
    key_t key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface lkt_rsp_if;
    import lkt_pkg::*;

    logic valid;
    logic ready;
    logic hit;
    logic evicted;
    key_t evicted_key;
    cnt_t occupancy;

    modport source (output valid, output hit, output evicted, output evicted_key,
                    output occupancy, input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_key,
                    input occupancy, output ready);
endinterface

>>> hw/rtl/lru_key_tracker_core.sv
// Top level of the LRU key tracker: a chain of recency cells and a response register.
// A response is registered and appears in the cycle after its request word is accepted.
// One word per cycle while ready is high; the compare, shift and count update all close together.
// Ready drops only while a response is held and the sink is not taking it.
// Reset (rst_n low, asynchronous) empties the tracker and sets capacity to 16;
// key slots are not cleared, only the occupancy count is.
module lru_key_tracker_core #(
    parameter int MAX_ENTRIES = lkt_pkg::MAX_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  lkt_pkg::cnt_t cfg_wdata,
    lkt_req_if.sink       req,
    lkt_rsp_if.source     rsp
);
    import lkt_pkg::*;

    // Capacity register and occupancy count.
    cnt_t     cap_reg;
    cnt_t     used_reg;
    cnt_t     used_next;

    // Response register.
    logic     rsp_valid_reg;
    logic     hit_reg;
    logic     evicted_reg;
    key_t     evicted_key_reg;
    cnt_t     occupancy_reg;

    logic     accept;
    logic     room;
    logic     hit;
    logic     evict;
    key_t     tail_key;
    lkt_ctl_t ctl;

    // Chain wiring: stop ripples from slot 0 toward the tail.
    logic [MAX_ENTRIES:0]   stop;
    logic [MAX_ENTRIES-1:0] last;
    key_t                   keys [MAX_ENTRIES];

    // Take a new word whenever the response register is free or being drained.
    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;

    // Room for an insert: below capacity (zero counts as one) and below the slot count.
    assign room = (32'(used_reg) < 32'(MAX_ENTRIES)) &&
                  ((used_reg < cap_reg) || ((cap_reg == '0) && (used_reg == '0)));

    assign ctl.advance = accept;
    assign ctl.room    = room;
    assign ctl.used    = used_reg;

    assign stop[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            key_t up_key;
            if (gi == 0)
            begin : g_head
                // Slot 0 always loads the accessed key.
                assign up_key = req.key;
            end
            else
            begin : g_body
                assign up_key = keys[gi-1];
            end

            lkt_cell #(
                .IDX (gi)
            ) u_cell (
                .clk          (clk),
                .ctl          (ctl),
                .lookup_key   (req.key),
                .upstream_key (up_key),
                .stop_in      (stop[gi]),
                .key_q        (keys[gi]),
                .stop_out     (stop[gi+1]),
                .last         (last[gi])
            );
        end
    endgenerate

    assign hit   = stop[MAX_ENTRIES];
    assign evict = ~hit & ~room;

    // Pick the least-recent key; at most one slot flags itself as the tail, exactly one when not empty.
    always_comb
    begin
        tail_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            tail_key = tail_key | (keys[i] & {KEY_W{last[i]}});
        end
    end

    // Grow only on a miss with room; hits and evictions keep the count.
    assign used_next = (~hit & room) ? used_reg + cnt_t'(1) : used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                used_reg      <= used_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response payload until the next accepted word replaces it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg         <= hit;
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? tail_key : '0;
            occupancy_reg   <= used_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.evicted     = evicted_reg;
    assign rsp.evicted_key = evicted_key_reg;
    assign rsp.occupancy   = occupancy_reg;

endmodule

>>> hw/rtl/lkt_cell.sv
// One recency slot: holds a key, compares it, and takes its upstream neighbor's key on a shift.
module lkt_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  lkt_pkg::lkt_ctl_t ctl,
    input  lkt_pkg::key_t    lookup_key,
    input  lkt_pkg::key_t    upstream_key,
    input  logic             stop_in,
    output lkt_pkg::key_t    key_q,
    output logic             stop_out,
    output logic             last
);
    import lkt_pkg::*;

    key_t key_reg;
    logic occ;
    logic at_end;
    logic shift;

    assign occ      = 32'(IDX) < 32'(ctl.used);
    assign at_end   = 32'(IDX) == 32'(ctl.used);
    assign last     = (32'(IDX) + 32'd1) == 32'(ctl.used);
    // Stop the shift wave below the first matching occupied slot.
    assign stop_out = stop_in | (occ & (key_reg == lookup_key));
    assign shift    = ctl.advance & ~stop_in & (occ | (at_end & ctl.room));
    assign key_q    = key_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= upstream_key;
        end
    end

endmodule

>>> hw/rtl/lkt_checker.sv
// Port-level checks for the LRU key tracker, bound to the top level.
module lkt_checker #(
    parameter int MAX_ENTRIES = lkt_pkg::MAX_ENTRIES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input logic          rsp_hit,
    input logic          rsp_evicted,
    input lkt_pkg::key_t rsp_evicted_key,
    input lkt_pkg::cnt_t rsp_occupancy
);
    import lkt_pkg::*;

    // Every accepted word produces a response on the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted word produced no response");

    // A hit never evicts, and after an access the tracker is never empty and holds at most MAX_ENTRIES keys.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!(rsp_hit && rsp_evicted) && (rsp_occupancy != '0) &&
                       (32'(rsp_occupancy) <= 32'(MAX_ENTRIES))))
        else $error("inconsistent hit, eviction or occupancy");

    // The evicted key reads zero when nothing was evicted.
    a_ev_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
        else $error("evicted key nonzero without eviction");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted) &&
             $stable(rsp_evicted_key) && $stable(rsp_occupancy)))
        else $error("stalled response changed");

endmodule

bind lru_key_tracker_core lkt_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_lkt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key),
    .rsp_occupancy   (rsp.occupancy)
);
